>>> hw/rtl/text_console_writer_macros.svh
// Assertion macros for the checker file of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
`default_nettype none

package tcw_pkg;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int IDX_W   = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int WORD_W  = 16;
  localparam int LIN_W   = 13;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'h20;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR  = 8'h0F;
  localparam logic [WORD_W-1:0] DEFAULT_BLANK = {DEFAULT_ATTR, BLANK_CHAR};

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_PUT,
    KIND_NEWLINE,
    KIND_CLEAR,
    KIND_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [CHAR_W-1:0]   char_code;
    logic [2*COLOR_W-1:0] attr;
    logic [IDX_W-1:0]    cell_index;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Top level of the text console writer: front end, command queue and back end.
// Each transaction puts one character, clears the screen or reads one cell, and
// returns one result with the cursor position after it. After reset the block
// blanks all COLUMNS*ROWS cells with 0x0F20, one cell per cycle, and stalls its
// input until that is done. A clear rewrites every cell, and a put or newline
// that scrolls moves all rows up and blanks the bottom row, both through the
// single write port of the cell buffer.
// A stalled result holds the back end until it is taken.
// A two-entry queue lets the input keep accepting while a result waits.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic [COLOR_W-1:0] foreground_i,
  input  wire logic [COLOR_W-1:0] background_i,
  input  wire logic [IDX_W-1:0]   cell_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [ROW_W-1:0]   row_now_o,
  output      logic [COL_W-1:0]   column_now_o,
  output      logic [IDX_W-1:0]   cursor_linear_o,
  output      logic [WORD_W-1:0]  cell_word_o
);

  cmd_t head;
  logic empty;
  logic pop;
  logic init_busy;

  tcw_front #(
    .CELL_COUNT(COLUMNS * ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .char_code_i (char_code_i),
    .foreground_i(foreground_i),
    .background_i(background_i),
    .cell_index_i(cell_index_i),
    .hold_i      (init_busy),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_now_o      (row_now_o),
    .column_now_o   (column_now_o),
    .cursor_linear_o(cursor_linear_o),
    .cell_word_o    (cell_word_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tcw_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int CELL_COUNT = 2000
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic [COLOR_W-1:0] foreground_i,
  input  wire logic [COLOR_W-1:0] background_i,
  input  wire logic [IDX_W-1:0]   cell_index_i,
  input  wire logic               hold_i,
  input  wire logic               pop_i,
  output      cmd_t               head_o,
  output      logic               empty_o
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             push;
  logic             pop;
  cmd_t             cmd;

  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign in_stall_o = full || hold_i;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && !empty_o;
  assign head_o     = queue_q[rd_ptr_q];

  always_comb begin
    cmd.kind       = KIND_NOP;
    cmd.char_code  = char_code_i;
    cmd.attr       = {background_i, foreground_i};
    cmd.cell_index = cell_index_i;
    case (operation_i)
      OP_PUT: begin
        cmd.kind = (char_code_i == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PUT;
      end
      OP_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      OP_READ: begin
        if (32'(cell_index_i) < 32'(CELL_COUNT)) begin
          cmd.kind = KIND_READ;
        end
      end
      default: begin
        cmd.kind = KIND_NOP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_back.sv
// Back end: cell buffer, cursor, fill and scroll sequencer, and result register.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire cmd_t              head_i,
  output      logic              pop_o,
  output      logic              init_busy_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ROW_W-1:0]  row_now_o,
  output      logic [COL_W-1:0]  column_now_o,
  output      logic [IDX_W-1:0]  cursor_linear_o,
  output      logic [WORD_W-1:0] cell_word_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_COUNT - COLUMNS);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [WORD_W-1:0] mem [CELL_COUNT];
  logic [WORD_W-1:0] rdata_q;

  logic [2:0]        state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] wa_q, wa_d;
  logic              pend_q, pend_d;
  logic [WORD_W-1:0] blank_q, blank_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [IDX_W-1:0]  out_lin_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_load;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;

  logic [LIN_W-1:0]  pos_full;
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    put_row;
  logic              put_scroll;
  logic              nl_scroll;

  assign pos_full   = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);
  assign row_inc    = {1'b0, row_q} + 1'b1;
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign put_row    = (col_inc == (COL_W + 1)'(COLUMNS)) ? row_inc : {1'b0, row_q};
  assign put_scroll = (put_row == (ROW_W + 1)'(ROWS));
  assign nl_scroll  = (row_inc == (ROW_W + 1)'(ROWS));

  assign init_busy_o = (state_q == ST_INIT);

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    cnt_d    = cnt_q;
    wa_d     = cnt_q;
    pend_d   = 1'b0;
    blank_d  = blank_q;
    word_d   = word_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = blank_q;
    raddr    = ADDR_W'(32'(cnt_q) + 32'(COLUMNS));
    out_load = 1'b0;
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = DEFAULT_BLANK;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          word_d = '0;
          case (head_i.kind)
            KIND_PUT: begin
              we    = 1'b1;
              waddr = ADDR_W'(pos_full);
              wdata = {head_i.attr, head_i.char_code};
              col_d = (col_inc == (COL_W + 1)'(COLUMNS)) ? '0 : col_inc[COL_W-1:0];
              if (put_scroll) begin
                row_d   = ROW_W'(ROWS - 1);
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                row_d   = put_row[ROW_W-1:0];
                state_d = ST_RESP;
              end
            end
            KIND_NEWLINE: begin
              col_d = '0;
              if (nl_scroll) begin
                row_d   = ROW_W'(ROWS - 1);
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                row_d   = row_inc[ROW_W-1:0];
                state_d = ST_RESP;
              end
            end
            KIND_CLEAR: begin
              blank_d = {head_i.attr, BLANK_CHAR};
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              state_d = ST_FILL;
            end
            KIND_READ: begin
              raddr   = ADDR_W'(head_i.cell_index);
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_READ: begin
        word_d  = rdata_q;
        state_d = ST_RESP;
      end
      ST_SCROLL: begin
        pend_d = 1'b1;
        we     = pend_q;
        waddr  = wa_q;
        wdata  = rdata_q;
        if (cnt_q == COPY_LAST) begin
          state_d = ST_TAIL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TAIL: begin
        we      = 1'b1;
        waddr   = wa_q;
        wdata   = rdata_q;
        cnt_d   = BOTTOM_ROW;
        blank_d = DEFAULT_BLANK;
        state_d = ST_FILL;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q    <= wa_d;
    blank_q <= blank_d;
    word_q  <= word_d;
    if (out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_lin_q  <= pos_full[IDX_W-1:0];
      out_word_q <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign row_now_o       = out_row_q;
  assign column_now_o    = out_col_q;
  assign cursor_linear_o = out_lin_q;
  assign cell_word_o     = out_word_q;

endmodule

`default_nettype wire

>>> hw/rtl/tcw_checker.sv
// Port-level assertions for the text console writer and their bind statement.
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ROW_W-1:0]  row_now_o,
  input wire logic [COL_W-1:0]  column_now_o,
  input wire logic [IDX_W-1:0]  cursor_linear_o,
  input wire logic [WORD_W-1:0] cell_word_o
);

  logic [LIN_W-1:0] lin_expected;

  assign lin_expected = LIN_W'(row_now_o) * LIN_W'(COLUMNS) + LIN_W'(column_now_o);

  `TCW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(cell_word_o) && $stable(cursor_linear_o), "Stalled result transaction changed.")
  `TCW_ASSERT_IMP(a_cursor_range, clk_i, rst_ni, out_valid_o, (32'(row_now_o) < 32'(ROWS)) && (32'(column_now_o) < 32'(COLUMNS)), "Cursor is outside the screen.")
  `TCW_ASSERT_IMP(a_cursor_linear, clk_i, rst_ni, out_valid_o, cursor_linear_o == lin_expected[IDX_W-1:0], "Linear cursor does not match row and column.")

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
